// ===== rtl/core/mfd_ua_pkg.sv =====
// Package for the upslope area accumulation block: state and mode codes,
// register indexes, field widths and the neighbor distance select.
// No dependencies.
package mfd_ua_pkg;

   localparam int ELEV_W = 32;
   localparam int AREA_W = 48;
   localparam int DIST_W = 32;
   localparam int SUM_W  = 52;            // nine weights below 2^48 each
   localparam int PROD_W = 2 * AREA_W;    // area times weight
   localparam int LEFT_OUT_W  = 17;
   localparam int SWEEP_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // elevations at or below -10000.0 count as missing data
   localparam logic signed [ELEV_W-1:0] ELEV_FLOOR = -32'sd655360000;

   // 3x3 neighbor index, row-major from the north-west corner
   localparam logic [3:0] NBR_CENTER = 4'd4;
   localparam logic [3:0] NBR_LAST   = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_NS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_EW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_DIAG  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SWEEPS = 3'd5;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_READ = 2'd2,
      MODE_NONE = 2'd3
   } mfd_mode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RD_WAIT,
      S_CLR,
      S_MK_RD,
      S_MK_CHK,
      S_CT_RD,
      S_CT_CEN,
      S_CT_NRD,
      S_CT_NCHK,
      S_SW_START,
      S_SW_RD,
      S_SW_CEN,
      S_SW_WRD,
      S_SW_WCHK,
      S_SW_WDIV,
      S_SW_SNEXT,
      S_SW_MUL,
      S_SW_SDIV,
      S_SW_ARD,
      S_SW_AWR,
      S_SW_FIN,
      S_SW_PASS,
      S_DONE
   } mfd_state_type;

   // spacing toward neighbor k; a zero register acts as one
   function automatic logic [DIST_W-1:0] dist_sel(input logic [3:0] k,
                                                 input logic [DIST_W-1:0] ns,
                                                 input logic [DIST_W-1:0] ew,
                                                 input logic [DIST_W-1:0] diag);
      logic [DIST_W-1:0] d;
      unique case (k)
         4'd0, 4'd2, 4'd6, 4'd8: d = diag;
         4'd1, 4'd7:             d = ns;
         default:                d = ew;
      endcase
      if (d == '0) begin
         d = DIST_W'(1);
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/mfd_upslope_area_accumulation_top.sv =====
// Multiple flow direction upslope area accumulation over a stored grid; depends on mfd_ua_pkg.
// A load word writes one cell in the cycle that it is taken. A read word's result is loaded
// into the output register from S_RD_WAIT once that register is free. A run word holds the
// block, its pace set by one read and one write port per store and one shared serial
// divide/multiply unit: a clearing pass over every cell, then a pass over the interior cells
// to mark routing cells, a pass that counts upslope cells for the routing cells, then sweeps;
// in each sweep every cell that propagates reads its neighbors and runs a 48-step divide for
// the weight of each lower neighbor, then for each lower neighbor a dispatch, 48-step
// multiply, 96-step divide and read-modify-write, and then the cell is retired. req_stall is
// high from a run or read until its result or status word has been loaded into the output
// register.
module mfd_upslope_area_accumulation_top
   import mfd_ua_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_row,
   input  logic [7:0]            req_col,
   input  logic signed [ELEV_W-1:0] req_elevation,
   input  logic                  req_elev_valid,
   input  logic [AREA_W-1:0]     req_cell_area,
   input  logic                  req_is_channel,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [AREA_W-1:0]     rsp_area_value,
   output logic [LEFT_OUT_W-1:0] rsp_cells_left,
   output logic [SWEEP_W-1:0]    rsp_sweeps_done,
   output logic                  rsp_is_run_status,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int LW    = $clog2(CELLS + 1);

   // configuration
   logic [8:0]           grid_rows_ff, grid_cols_ff;
   logic [DIST_W-1:0]    dist_ns_ff, dist_ew_ff, dist_diag_ff;
   logic [SWEEP_W-1:0]   max_sweeps_ff;

   // cell stores
   logic signed [ELEV_W-1:0] elev_mem  [CELLS];
   logic                     valid_mem [CELLS];
   logic [AREA_W-1:0]        area_mem  [CELLS];
   logic                     chan_mem  [CELLS];
   logic                     rout_mem  [CELLS];
   logic [3:0]               pend_mem  [CELLS];

   logic signed [ELEV_W-1:0] elev_rd_ff;
   logic                     valid_rd_ff, chan_rd_ff, rout_rd_ff;
   logic [AREA_W-1:0]        area_rd_ff;
   logic [3:0]               pend_rd_ff;

   logic [AW-1:0]     raddr, waddr;
   logic              cell_we, area_we, rout_we, pend_we, rout_wd;
   logic [AREA_W-1:0] area_wd;
   logic [3:0]        pend_wd;

   // sequencer
   mfd_state_type state_ff, state_in;
   logic [3:0]    k_ff, k_in;
   logic [NRW-1:0] ci_ff, ci_in;
   logic [NCW-1:0] cj_ff, cj_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           inside_ff, inside_in;
   logic           ok_ff, ok_in;
   logic           moved_ff, moved_in;
   logic signed [ELEV_W-1:0] ec_ff, ec_in;
   logic [AREA_W-1:0] src_ff, src_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [AREA_W-1:0] w_ff [9];
   logic [AREA_W-1:0] w_in [9];
   logic [LW-1:0]      left_ff, left_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;

   // shared serial unit: restoring divider and shift-add multiplier
   logic [SUM_W-1:0]  div_rem_ff, div_rem_in;
   logic [SUM_W-1:0]  div_den_ff, div_den_in;
   logic [PROD_W-1:0] div_num_ff, div_num_in;
   logic [AREA_W-1:0] div_quo_ff, div_quo_in;
   logic [6:0]        div_cnt_ff, div_cnt_in;
   logic [AREA_W-1:0] mul_hi_ff, mul_hi_in, mul_lo_ff, mul_lo_in;
   logic [5:0]        mul_cnt_ff, mul_cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]     rsp_area_ff, rsp_area_in;
   logic [LEFT_OUT_W-1:0] rsp_left_ff, rsp_left_in;
   logic [SWEEP_W-1:0]    rsp_sweeps_ff, rsp_sweeps_in;
   logic                  rsp_run_ff, rsp_run_in;

   logic [NRW-1:0] nr;
   logic [NCW-1:0] nc;
   logic           has_interior, last_col, pass_last, cell_adv, rsp_free;
   logic [AW-1:0]  cen, nbr, ld_addr;
   logic           ld_inside;
   logic [SUM_W:0] div_t;
   logic           div_ge;
   logic [SUM_W-1:0]  div_rem_n;
   logic [AREA_W-1:0] div_quo_n;
   logic [AREA_W:0]   mul_sum;
   logic [PROD_W-1:0] mul_prod_n;
   logic signed [ELEV_W:0] drop;
   logic              cell_ok, ok_n;
   logic [AREA_W:0]   area_sum;
   logic [AREA_W-1:0] w_cur;

   function automatic logic [AW-1:0] nbr_addr(input logic [AW-1:0] c, input logic [3:0] k);
      logic [AW-1:0] a;
      unique case (k)
         4'd0:    a = c - AW'(MAX_COLS + 1);
         4'd1:    a = c - AW'(MAX_COLS);
         4'd2:    a = c - AW'(MAX_COLS - 1);
         4'd3:    a = c - AW'(1);
         4'd5:    a = c + AW'(1);
         4'd6:    a = c + AW'(MAX_COLS - 1);
         4'd7:    a = c + AW'(MAX_COLS);
         4'd8:    a = c + AW'(MAX_COLS + 1);
         default: a = c;
      endcase
      return a;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_area_value    = rsp_area_ff;
   assign rsp_cells_left    = rsp_left_ff;
   assign rsp_sweeps_done   = rsp_sweeps_ff;
   assign rsp_is_run_status = rsp_run_ff;

   assign nr = (grid_rows_ff >= MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(grid_rows_ff);
   assign nc = (grid_cols_ff >= MAX_COLS) ? NCW'(MAX_COLS) : NCW'(grid_cols_ff);
   assign has_interior = (nr >= NRW'(3)) && (nc >= NCW'(3));
   assign last_col  = ({1'b0, cj_ff} + (NCW+1)'(2)) >= {1'b0, nc};
   assign pass_last = last_col && (({1'b0, ci_ff} + (NRW+1)'(2)) >= {1'b0, nr});
   assign cen = row_base_ff + AW'(cj_ff);
   assign nbr = nbr_addr(cen, k_ff);
   assign ld_inside = (req_row < MAX_ROWS) && (req_col < MAX_COLS);
   assign ld_addr = AW'(req_row) * AW'(MAX_COLS) + AW'(req_col);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // one restoring divide step
   assign div_t     = {div_rem_ff, div_num_ff[PROD_W-1]};
   assign div_ge    = div_t >= {1'b0, div_den_ff};
   assign div_rem_n = div_ge ? SUM_W'(div_t - {1'b0, div_den_ff}) : SUM_W'(div_t);
   assign div_quo_n = {div_quo_ff[AREA_W-2:0], div_ge};

   // one shift-add multiply step, LSB first
   assign w_cur      = w_ff[k_ff];
   assign mul_sum    = mul_lo_ff[0] ? ({1'b0, mul_hi_ff} + {1'b0, w_cur}) : {1'b0, mul_hi_ff};
   assign mul_prod_n = {mul_sum, mul_lo_ff[AREA_W-1:1]};

   assign drop     = {ec_ff[ELEV_W-1], ec_ff} - {elev_rd_ff[ELEV_W-1], elev_rd_ff};
   assign cell_ok  = valid_rd_ff && (elev_rd_ff > ELEV_FLOOR);
   assign ok_n     = ok_ff && cell_ok &&
                     ((k_ff != NBR_CENTER) || (!chan_rd_ff && (area_rd_ff != '0)));
   assign area_sum = {1'b0, area_rd_ff} + {1'b0, div_quo_ff};

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      ci_in       = ci_ff;
      cj_in       = cj_ff;
      row_base_in = row_base_ff;
      clr_in      = clr_ff;
      addr_in     = addr_ff;
      inside_in   = inside_ff;
      ok_in       = ok_ff;
      moved_in    = moved_ff;
      ec_in       = ec_ff;
      src_in      = src_ff;
      sum_in      = sum_ff;
      w_in        = w_ff;
      left_in     = left_ff;
      sweep_in    = sweep_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      div_num_in  = div_num_ff;
      div_quo_in  = div_quo_ff;
      div_cnt_in  = div_cnt_ff;
      mul_hi_in   = mul_hi_ff;
      mul_lo_in   = mul_lo_ff;
      mul_cnt_in  = mul_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_area_in   = rsp_area_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_sweeps_in = rsp_sweeps_ff;
      rsp_run_in    = rsp_run_ff;
      raddr   = nbr;
      waddr   = nbr;
      cell_we = 1'b0;
      area_we = 1'b0;
      area_wd = req_cell_area;
      rout_we = 1'b0;
      rout_wd = 1'b0;
      pend_we = 1'b0;
      pend_wd = '0;
      cell_adv = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            raddr = ld_addr;
            waddr = ld_addr;
            if (req_valid) begin
               unique case (mfd_mode_type'(req_mode))
                  MODE_LOAD: begin
                     cell_we = ld_inside;
                     area_we = ld_inside;
                  end
                  MODE_RUN: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  MODE_READ: begin
                     addr_in   = ld_addr;
                     inside_in = ld_inside;
                     state_in  = S_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            raddr = addr_ff;
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_area_in   = inside_ff ? area_rd_ff : '0;
               rsp_left_in   = '0;
               rsp_sweeps_in = '0;
               rsp_run_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CLR: begin
            waddr   = clr_ff;
            rout_we = 1'b1;
            pend_we = 1'b1;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               left_in     = '0;
               sweep_in    = '0;
               ci_in       = NRW'(1);
               cj_in       = NCW'(1);
               row_base_in = AW'(MAX_COLS);
               k_in        = '0;
               ok_in       = 1'b1;
               state_in    = has_interior ? S_MK_RD : S_SW_START;
            end
         end
         S_MK_RD: begin
            state_in = S_MK_CHK;
         end
         S_MK_CHK: begin
            if (k_ff == NBR_LAST) begin
               waddr    = cen;
               rout_we  = 1'b1;
               rout_wd  = ok_n;
               left_in  = left_ff + LW'(ok_n);
               k_in     = '0;
               ok_in    = 1'b1;
               cell_adv = 1'b1;
               state_in = pass_last ? S_CT_RD : S_MK_RD;
            end else begin
               ok_in    = ok_n;
               k_in     = k_ff + 4'd1;
               state_in = S_MK_RD;
            end
         end
         S_CT_RD: begin
            raddr    = cen;
            state_in = S_CT_CEN;
         end
         S_CT_CEN: begin
            if (!rout_rd_ff) begin
               cell_adv = 1'b1;
               state_in = pass_last ? S_SW_START : S_CT_RD;
            end else begin
               ec_in    = elev_rd_ff;
               k_in     = '0;
               state_in = S_CT_NRD;
            end
         end
         S_CT_NRD: begin
            state_in = S_CT_NCHK;
         end
         S_CT_NCHK: begin
            pend_we = (elev_rd_ff < ec_ff);
            pend_wd = pend_rd_ff + 4'd1;
            if (k_ff == NBR_LAST) begin
               cell_adv = 1'b1;
               state_in = pass_last ? S_SW_START : S_CT_RD;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_CT_NRD;
            end
         end
         S_SW_START: begin
            if ((left_ff != '0) && (sweep_ff < max_sweeps_ff)) begin
               moved_in = 1'b0;
               state_in = S_SW_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SW_RD: begin
            raddr    = cen;
            state_in = S_SW_CEN;
         end
         S_SW_CEN: begin
            if (!rout_rd_ff || (pend_rd_ff != '0)) begin
               cell_adv = 1'b1;
               state_in = pass_last ? S_SW_PASS : S_SW_RD;
            end else begin
               ec_in    = elev_rd_ff;
               src_in   = area_rd_ff;
               sum_in   = '0;
               k_in     = '0;
               state_in = S_SW_WRD;
            end
         end
         S_SW_WRD: begin
            state_in = S_SW_WCHK;
         end
         S_SW_WCHK: begin
            if (!drop[ELEV_W] && (drop != '0)) begin
               // weight = (drop << 16) / distance
               div_num_in = {drop[ELEV_W-1:0], 64'd0};
               div_den_in = SUM_W'(dist_sel(k_ff, dist_ns_ff, dist_ew_ff, dist_diag_ff));
               div_rem_in = '0;
               div_quo_in = '0;
               div_cnt_in = 7'd48;
               state_in   = S_SW_WDIV;
            end else begin
               w_in[k_ff] = '0;
               if (k_ff == NBR_LAST) begin
                  k_in     = '0;
                  state_in = S_SW_SNEXT;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_SW_WRD;
               end
            end
         end
         S_SW_WDIV: begin
            div_rem_in = div_rem_n;
            div_quo_in = div_quo_n;
            div_num_in = {div_num_ff[PROD_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 7'd1;
            if (div_cnt_ff == 7'd1) begin
               w_in[k_ff] = (div_quo_n == '0) ? AREA_W'(1) : div_quo_n;
               sum_in     = sum_ff + SUM_W'((div_quo_n == '0) ? AREA_W'(1) : div_quo_n);
               if (k_ff == NBR_LAST) begin
                  k_in     = '0;
                  state_in = S_SW_SNEXT;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_SW_WRD;
               end
            end
         end
         S_SW_SNEXT: begin
            if (w_cur == '0) begin
               if (k_ff == NBR_LAST) begin
                  state_in = S_SW_FIN;
               end else begin
                  k_in = k_ff + 4'd1;
               end
            end else begin
               mul_hi_in  = '0;
               mul_lo_in  = src_ff;
               mul_cnt_in = 6'd48;
               state_in   = S_SW_MUL;
            end
         end
         S_SW_MUL: begin
            mul_hi_in  = mul_prod_n[PROD_W-1:AREA_W];
            mul_lo_in  = mul_prod_n[AREA_W-1:0];
            mul_cnt_in = mul_cnt_ff - 6'd1;
            if (mul_cnt_ff == 6'd1) begin
               // share = area * weight / sum of weights
               div_num_in = mul_prod_n;
               div_den_in = sum_ff;
               div_rem_in = '0;
               div_quo_in = '0;
               div_cnt_in = 7'd96;
               state_in   = S_SW_SDIV;
            end
         end
         S_SW_SDIV: begin
            div_rem_in = div_rem_n;
            div_quo_in = div_quo_n;
            div_num_in = {div_num_ff[PROD_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 7'd1;
            if (div_cnt_ff == 7'd1) begin
               state_in = S_SW_ARD;
            end
         end
         S_SW_ARD: begin
            state_in = S_SW_AWR;
         end
         S_SW_AWR: begin
            area_we = 1'b1;
            area_wd = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
            pend_we = 1'b1;
            pend_wd = pend_rd_ff - 4'd1;
            if (k_ff == NBR_LAST) begin
               state_in = S_SW_FIN;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_SW_SNEXT;
            end
         end
         S_SW_FIN: begin
            waddr    = cen;
            rout_we  = 1'b1;
            left_in  = left_ff - LW'(1);
            moved_in = 1'b1;
            cell_adv = 1'b1;
            state_in = pass_last ? S_SW_PASS : S_SW_RD;
         end
         S_SW_PASS: begin
            if (!moved_ff) begin
               // a sweep that moves nothing means no later one can
               sweep_in = max_sweeps_ff;
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + SWEEP_W'(1);
               state_in = S_SW_START;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_area_in   = '0;
               rsp_left_in   = LEFT_OUT_W'(left_ff);
               rsp_sweeps_in = sweep_ff;
               rsp_run_in    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cell_adv) begin
         if (pass_last) begin
            ci_in       = NRW'(1);
            cj_in       = NCW'(1);
            row_base_in = AW'(MAX_COLS);
         end else if (last_col) begin
            ci_in       = ci_ff + NRW'(1);
            cj_in       = NCW'(1);
            row_base_in = row_base_ff + AW'(MAX_COLS);
         end else begin
            cj_in = cj_ff + NCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         elev_mem[waddr]  <= req_elevation;
         valid_mem[waddr] <= req_elev_valid;
         chan_mem[waddr]  <= req_is_channel;
      end
      if (area_we) begin
         area_mem[waddr] <= area_wd;
      end
      if (rout_we) begin
         rout_mem[waddr] <= rout_wd;
      end
      if (pend_we) begin
         pend_mem[waddr] <= pend_wd;
      end
      elev_rd_ff  <= elev_mem[raddr];
      valid_rd_ff <= valid_mem[raddr];
      area_rd_ff  <= area_mem[raddr];
      chan_rd_ff  <= chan_mem[raddr];
      rout_rd_ff  <= rout_mem[raddr];
      pend_rd_ff  <= pend_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         left_ff       <= '0;
         sweep_ff      <= '0;
         grid_rows_ff  <= 9'd256;
         grid_cols_ff  <= 9'd256;
         dist_ns_ff    <= 32'd65536;
         dist_ew_ff    <= 32'd65536;
         dist_diag_ff  <= 32'd92682;
         max_sweeps_ff <= 16'd1000;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         sweep_ff     <= sweep_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata[8:0];
               CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata[8:0];
               CSR_DIST_NS:    dist_ns_ff    <= csr_wdata;
               CSR_DIST_EW:    dist_ew_ff    <= csr_wdata;
               CSR_DIST_DIAG:  dist_diag_ff  <= csr_wdata;
               CSR_MAX_SWEEPS: max_sweeps_ff <= csr_wdata[SWEEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      row_base_ff <= row_base_in;
      clr_ff      <= clr_in;
      addr_ff     <= addr_in;
      inside_ff   <= inside_in;
      ok_ff       <= ok_in;
      moved_ff    <= moved_in;
      ec_ff       <= ec_in;
      src_ff      <= src_in;
      sum_ff      <= sum_in;
      w_ff        <= w_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_num_ff  <= div_num_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      mul_hi_ff   <= mul_hi_in;
      mul_lo_ff   <= mul_lo_in;
      mul_cnt_ff  <= mul_cnt_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_sweeps_ff <= rsp_sweeps_in;
      rsp_run_ff    <= rsp_run_in;
   end

`ifndef ASSERT_OFF
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RD_WAIT || state_ff == S_DONE))
      else $error("result word appeared outside a read or run completion");
   a_fin_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_FIN) |-> (left_ff != '0))
      else $error("cell propagated with no routing cells left");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_WDIV || state_ff == S_SW_SDIV) |-> (div_rem_ff < div_den_ff))
      else $error("divider remainder not below divisor");
   a_sum_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_MUL) |-> (sum_ff != '0))
      else $error("share computed with zero weight sum");
`endif

endmodule
